### design/qtsm_pkg.sv
// types, codes and defaults shared by the quarter-turn scale coordinate mapper
package qtsm_pkg;

    localparam int FRACTION_BITS_DEF = 32;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_ORIGIN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_WIDTH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_HEIGHT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DEST_ORIGIN   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DEST_WIDTH    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DEST_HEIGHT   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ROTATION      = 3'd6;

    // status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_INVALID   = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_OVERFLOW  = 2'd3;

    // clockwise quarter turns
    localparam logic [1:0] ROT_0   = 2'd0;
    localparam logic [1:0] ROT_90  = 2'd1;
    localparam logic [1:0] ROT_180 = 2'd2;
    localparam logic [1:0] ROT_270 = 2'd3;

    localparam logic ACT_POINT = 1'b0;

    typedef struct packed {
        logic               action;
        logic signed [31:0] coord_x;
        logic signed [31:0] coord_y;
        logic signed [31:0] extent_w;
        logic signed [31:0] extent_h;
    } req_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic [30:0]        out_w;
        logic [30:0]        out_h;
    } rsp_t;

endpackage

### design/qtsm_stream_if.sv
// valid/ready stream channel carrying one payload per transaction
interface qtsm_stream_if #(parameter type payload_t = logic [0:0]);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### design/quarter_turn_scale_coord_mapper_unit.sv
// quarter-turn rotate and per-axis fixed-point scale mapper for points and rectangles
//
//  channel  dir  payload                                   transaction when
//  req      in   action, coord_x, coord_y, extent_w/h      req.valid && req.ready
//  rsp      out  status, out_x, out_y, out_w, out_h        rsp.valid && rsp.ready
//  cfg      in   cfg_index, cfg_wdata                      cfg_we
//
//  seven register stages, one request per cycle while the divider is idle and rsp is not stalled
//  a register write starts a restoring divider, one quotient bit per cycle, one axis
//  after the other: req.ready stays low until both axes are done
//  after reset the factors hold unity and requests are taken at once
//  a stall at rsp freezes every stage together; nothing is dropped or repeated
module quarter_turn_scale_coord_mapper_unit #(
    parameter int FRACTION_BITS = qtsm_pkg::FRACTION_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [qtsm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [qtsm_pkg::CFG_DATA_W-1:0] cfg_wdata,
    qtsm_stream_if.sink                     req,
    qtsm_stream_if.source                   rsp
);

    localparam int NW    = 31 + FRACTION_BITS;
    localparam int CNT_W = $clog2(NW + 1);
    localparam int HI_W  = NW - 32;
    localparam int SUM_W = 31 + NW + 1;
    localparam logic [NW-1:0]    UNITY     = NW'(1) << FRACTION_BITS;
    localparam logic [SUM_W-1:0] HALF_BIAS = SUM_W'(1) << (FRACTION_BITS - 1);
    localparam logic [SUM_W-1:0] CEIL_BIAS = (SUM_W'(1) << FRACTION_BITS) - SUM_W'(1);
    localparam logic signed [33:0] IMAX = 34'sd2147483647;
    localparam logic signed [33:0] IMIN = -34'sd2147483648;

    // configuration registers
    logic [63:0] src_org_reg, dst_org_reg;
    logic [30:0] src_w_reg, src_h_reg, dst_w_reg, dst_h_reg;
    logic [1:0]  rot_reg;
    logic        cfg_hit;

    // divider and factors
    logic           busy_reg, start_reg, axis_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [31:0]    rem_reg;
    logic [NW-1:0]  quo_reg;
    logic [NW-1:0]  xf_reg, xc_reg, xn_reg, yf_reg, yc_reg, yn_reg;
    logic [30:0]    div_d, div_n;
    logic [31:0]    div_tmp, div_rem_next;
    logic           div_ge, div_last, near_inc, ceil_inc;
    logic [NW-1:0]  div_quo_next;

    logic signed [33:0] sx, sy, dx, dy, sw34, sh34, tr, tb;
    logic [30:0] rw, rh;
    logic        cfg_ok, adv;

    assign sx   = signed'({{2{src_org_reg[31]}}, src_org_reg[31:0]});
    assign sy   = signed'({{2{src_org_reg[63]}}, src_org_reg[63:32]});
    assign dx   = signed'({{2{dst_org_reg[31]}}, dst_org_reg[31:0]});
    assign dy   = signed'({{2{dst_org_reg[63]}}, dst_org_reg[63:32]});
    assign sw34 = signed'({3'b000, src_w_reg});
    assign sh34 = signed'({3'b000, src_h_reg});
    assign tr   = sx + sw34;
    assign tb   = sy + sh34;
    assign rw   = rot_reg[0] ? src_h_reg : src_w_reg;
    assign rh   = rot_reg[0] ? src_w_reg : src_h_reg;

    assign cfg_ok = (src_w_reg != '0) && (src_h_reg != '0) && (dst_w_reg != '0)
                 && (dst_h_reg != '0) && (tr <= IMAX) && (tb <= IMAX)
                 && (dx + signed'({3'b000, dst_w_reg}) <= IMAX)
                 && (dy + signed'({3'b000, dst_h_reg}) <= IMAX);

    assign cfg_hit = cfg_we && (cfg_index <= qtsm_pkg::REG_ROTATION);

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            src_org_reg <= '0;
            dst_org_reg <= '0;
            src_w_reg   <= 31'd1;
            src_h_reg   <= 31'd1;
            dst_w_reg   <= 31'd1;
            dst_h_reg   <= 31'd1;
            rot_reg     <= qtsm_pkg::ROT_0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                qtsm_pkg::REG_SOURCE_ORIGIN: src_org_reg <= cfg_wdata;
                qtsm_pkg::REG_SOURCE_WIDTH:  src_w_reg   <= cfg_wdata[30:0];
                qtsm_pkg::REG_SOURCE_HEIGHT: src_h_reg   <= cfg_wdata[30:0];
                qtsm_pkg::REG_DEST_ORIGIN:   dst_org_reg <= cfg_wdata;
                qtsm_pkg::REG_DEST_WIDTH:    dst_w_reg   <= cfg_wdata[30:0];
                qtsm_pkg::REG_DEST_HEIGHT:   dst_h_reg   <= cfg_wdata[30:0];
                qtsm_pkg::REG_ROTATION:      rot_reg     <= cfg_wdata[1:0];
                default: ;
            endcase
        end
    end

    // restoring division of dest extent << FRACTION_BITS by rotated source extent
    assign div_d        = axis_reg ? rh : rw;
    assign div_n        = axis_reg ? dst_h_reg : dst_w_reg;
    assign div_tmp      = {rem_reg[30:0], quo_reg[NW-1]};
    assign div_ge       = div_tmp >= {1'b0, div_d};
    assign div_rem_next = div_ge ? div_tmp - {1'b0, div_d} : div_tmp;
    assign div_quo_next = {quo_reg[NW-2:0], div_ge};
    assign div_last     = cnt_reg == CNT_W'(NW - 1);
    assign ceil_inc     = div_rem_next != '0;
    assign near_inc     = (div_rem_next + {2'b00, div_d[30:1]}) >= {1'b0, div_d};

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            busy_reg  <= 1'b0;
            start_reg <= 1'b0;
            axis_reg  <= 1'b0;
            cnt_reg   <= '0;
            xf_reg    <= UNITY;
            xc_reg    <= UNITY;
            xn_reg    <= UNITY;
            yf_reg    <= UNITY;
            yc_reg    <= UNITY;
            yn_reg    <= UNITY;
        end else if (cfg_hit) begin
            busy_reg  <= 1'b1;
            start_reg <= 1'b1;
            axis_reg  <= 1'b0;
        end else if (busy_reg) begin
            if (start_reg) begin
                start_reg <= 1'b0;
                cnt_reg   <= '0;
            end else begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (div_last) begin
                    if (axis_reg) begin
                        yf_reg   <= div_quo_next;
                        yc_reg   <= div_quo_next + NW'(ceil_inc);
                        yn_reg   <= div_quo_next + NW'(near_inc);
                        busy_reg <= 1'b0;
                    end else begin
                        xf_reg    <= div_quo_next;
                        xc_reg    <= div_quo_next + NW'(ceil_inc);
                        xn_reg    <= div_quo_next + NW'(near_inc);
                        axis_reg  <= 1'b1;
                        start_reg <= 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk) begin
        if (busy_reg) begin
            if (start_reg) begin
                rem_reg <= '0;
                quo_reg <= {div_n, {FRACTION_BITS{1'b0}}};
            end else begin
                rem_reg <= div_rem_next;
                quo_reg <= div_quo_next;
            end
        end
    end

    // pipeline
    logic rsp_valid_reg;
    qtsm_pkg::rsp_t rsp_data_reg;

    assign adv       = !rsp_valid_reg || rsp.ready;
    assign req.ready = adv && !busy_reg;
    assign rsp.valid = rsp_valid_reg;
    assign rsp.data  = rsp_data_reg;

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            v5_reg        <= 1'b0;
            v6_reg        <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end else if (adv) begin
            v1_reg        <= req.valid && !busy_reg;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            v4_reg        <= v3_reg;
            v5_reg        <= v4_reg;
            v6_reg        <= v5_reg;
            rsp_valid_reg <= v6_reg;
        end
    end

    // stage 1: offsets, far edges, clip near edges
    logic               a1_reg, ok1_reg, ewp1_reg, ehp1_reg;
    logic signed [33:0] lx1_reg, ly1_reg, cr1_reg, cb1_reg, cl1_reg, ct1_reg;
    logic signed [33:0] cx, cy, ew, eh;

    assign cx = signed'({{2{req.data.coord_x[31]}}, req.data.coord_x});
    assign cy = signed'({{2{req.data.coord_y[31]}}, req.data.coord_y});
    assign ew = signed'({{2{req.data.extent_w[31]}}, req.data.extent_w});
    assign eh = signed'({{2{req.data.extent_h[31]}}, req.data.extent_h});

    always_ff @(posedge clk) begin
        if (adv) begin
            a1_reg   <= req.data.action;
            ok1_reg  <= cfg_ok;
            ewp1_reg <= !req.data.extent_w[31] && (req.data.extent_w != '0);
            ehp1_reg <= !req.data.extent_h[31] && (req.data.extent_h != '0);
            lx1_reg  <= cx - sx;
            ly1_reg  <= cy - sy;
            cr1_reg  <= cx + ew;
            cb1_reg  <= cy + eh;
            cl1_reg  <= (cx > sx) ? cx : sx;
            ct1_reg  <= (cy > sy) ? cy : sy;
        end
    end

    // stage 2: range checks, clip far edges
    logic               a2_reg, ok2_reg, ptbad2_reg, rbad2_reg;
    logic signed [33:0] lx2_reg, ly2_reg, cl2_reg, ct2_reg, cr2_reg, cb2_reg;

    always_ff @(posedge clk) begin
        if (adv) begin
            a2_reg     <= a1_reg;
            ok2_reg    <= ok1_reg;
            ptbad2_reg <= (lx1_reg < 0) || (ly1_reg < 0) || (lx1_reg > sw34) || (ly1_reg > sh34);
            rbad2_reg  <= !ewp1_reg || !ehp1_reg || (cr1_reg > IMAX) || (cb1_reg > IMAX);
            lx2_reg    <= lx1_reg;
            ly2_reg    <= ly1_reg;
            cl2_reg    <= cl1_reg;
            ct2_reg    <= ct1_reg;
            cr2_reg    <= (tr < cr1_reg) ? tr : cr1_reg;
            cb2_reg    <= (tb < cb1_reg) ? tb : cb1_reg;
        end
    end

    // stage 3: overlap, early status, edges relative to source origin
    logic [1:0]         st2;
    logic [1:0]         st3_reg;
    logic               a3_reg;
    logic [30:0]        l3_reg, t3_reg, r3_reg, b3_reg;
    logic signed [33:0] l2, t2, r2, b2;

    assign l2 = cl2_reg - sx;
    assign t2 = ct2_reg - sy;
    assign r2 = cr2_reg - sx;
    assign b2 = cb2_reg - sy;

    always_comb begin
        priority if (!ok2_reg) begin
            st2 = qtsm_pkg::ST_INVALID;
        end else if (a2_reg == qtsm_pkg::ACT_POINT) begin
            st2 = ptbad2_reg ? qtsm_pkg::ST_INVALID : qtsm_pkg::ST_OK;
        end else if (rbad2_reg) begin
            st2 = qtsm_pkg::ST_INVALID;
        end else if ((cl2_reg >= cr2_reg) || (ct2_reg >= cb2_reg)) begin
            st2 = qtsm_pkg::ST_NOT_FOUND;
        end else begin
            st2 = qtsm_pkg::ST_OK;
        end
    end

    always_ff @(posedge clk) begin
        if (adv) begin
            a3_reg  <= a2_reg;
            st3_reg <= st2;
            if (a2_reg == qtsm_pkg::ACT_POINT) begin
                l3_reg <= lx2_reg[30:0];
                r3_reg <= lx2_reg[30:0];
                t3_reg <= ly2_reg[30:0];
                b3_reg <= ly2_reg[30:0];
            end else begin
                l3_reg <= l2[30:0];
                r3_reg <= r2[30:0];
                t3_reg <= t2[30:0];
                b3_reg <= b2[30:0];
            end
        end
    end

    // stage 4: rotation; lanes are left, top, right, bottom
    logic        a4_reg;
    logic [1:0]  st4_reg;
    logic [30:0] q4_reg [4];
    logic [30:0] q3 [4];

    always_comb begin
        unique case (rot_reg)
            qtsm_pkg::ROT_0: begin
                q3[0] = l3_reg;
                q3[1] = t3_reg;
                q3[2] = r3_reg;
                q3[3] = b3_reg;
            end
            qtsm_pkg::ROT_90: begin
                q3[0] = src_h_reg - b3_reg;
                q3[1] = l3_reg;
                q3[2] = src_h_reg - t3_reg;
                q3[3] = r3_reg;
            end
            qtsm_pkg::ROT_180: begin
                q3[0] = src_w_reg - r3_reg;
                q3[1] = src_h_reg - b3_reg;
                q3[2] = src_w_reg - l3_reg;
                q3[3] = src_h_reg - t3_reg;
            end
            default: begin
                q3[0] = t3_reg;
                q3[1] = src_w_reg - r3_reg;
                q3[2] = b3_reg;
                q3[3] = src_w_reg - l3_reg;
            end
        endcase
    end

    always_ff @(posedge clk) begin
        if (adv) begin
            a4_reg  <= a3_reg;
            st4_reg <= st3_reg;
            q4_reg  <= q3;
        end
    end

    // stages 5 and 6: per-lane scaling
    logic        a5_reg, a6_reg;
    logic [1:0]  st5_reg, st6_reg;
    logic [30:0] f6_reg [4];

    always_ff @(posedge clk) begin
        if (adv) begin
            a5_reg  <= a4_reg;
            st5_reg <= st4_reg;
            a6_reg  <= a5_reg;
            st6_reg <= st5_reg;
        end
    end

    for (genvar i = 0; i < 4; i++) begin : g_lane
        localparam bit IS_Y    = (i % 2) == 1;
        localparam bit IS_CEIL = i >= 2;

        logic [NW-1:0]      fac;
        logic [30:0]        src, dst;
        logic               z5_reg, full5_reg;
        logic [62:0]        plo5_reg;
        logic [31+HI_W-1:0] phi5_reg;
        logic [SUM_W-1:0]   bias, sum, shr;

        assign src = IS_Y ? rh : rw;
        assign dst = IS_Y ? dst_h_reg : dst_w_reg;

        always_comb begin
            if (IS_CEIL) begin
                fac = IS_Y ? yc_reg : xc_reg;
            end else if (a4_reg == qtsm_pkg::ACT_POINT) begin
                fac = IS_Y ? yn_reg : xn_reg;
            end else begin
                fac = IS_Y ? yf_reg : xf_reg;
            end
        end

        always_ff @(posedge clk) begin
            if (adv) begin
                z5_reg    <= q4_reg[i] == '0;
                full5_reg <= q4_reg[i] >= src;
                plo5_reg  <= 63'(q4_reg[i]) * 63'(fac[31:0]);
                phi5_reg  <= (31+HI_W)'(q4_reg[i]) * (31+HI_W)'(fac[NW-1:32]);
            end
        end

        assign bias = IS_CEIL ? CEIL_BIAS
                    : ((a5_reg == qtsm_pkg::ACT_POINT) ? HALF_BIAS : '0);
        assign sum  = SUM_W'(plo5_reg) + (SUM_W'(phi5_reg) << 32) + bias;
        assign shr  = sum >> FRACTION_BITS;

        always_ff @(posedge clk) begin
            if (adv) begin
                if (z5_reg) begin
                    f6_reg[i] <= '0;
                end else if (full5_reg || (shr > SUM_W'(dst))) begin
                    f6_reg[i] <= dst;
                end else begin
                    f6_reg[i] <= shr[30:0];
                end
            end
        end
    end

    // stage 7: destination placement, overflow, result register
    logic signed [33:0] ox, oy;
    logic signed [31:0] ow, oh;
    logic               pos_bad, ext_bad;
    logic [1:0]         st6;

    assign ox = dx + signed'({3'b000, f6_reg[0]});
    assign oy = dy + signed'({3'b000, f6_reg[1]});
    assign ow = signed'({1'b0, f6_reg[2]}) - signed'({1'b0, f6_reg[0]});
    assign oh = signed'({1'b0, f6_reg[3]}) - signed'({1'b0, f6_reg[1]});
    assign pos_bad = (ox > IMAX) || (ox < IMIN) || (oy > IMAX) || (oy < IMIN);
    assign ext_bad = (ow <= 0) || (oh <= 0);

    always_comb begin
        priority if (st6_reg != qtsm_pkg::ST_OK) begin
            st6 = st6_reg;
        end else if (pos_bad || ((a6_reg != qtsm_pkg::ACT_POINT) && ext_bad)) begin
            st6 = qtsm_pkg::ST_OVERFLOW;
        end else begin
            st6 = qtsm_pkg::ST_OK;
        end
    end

    always_ff @(posedge clk) begin
        if (adv) begin
            rsp_data_reg.status <= st6;
            if (st6 == qtsm_pkg::ST_OK) begin
                rsp_data_reg.out_x <= ox[31:0];
                rsp_data_reg.out_y <= oy[31:0];
                rsp_data_reg.out_w <= (a6_reg == qtsm_pkg::ACT_POINT) ? '0 : ow[30:0];
                rsp_data_reg.out_h <= (a6_reg == qtsm_pkg::ACT_POINT) ? '0 : oh[30:0];
            end else begin
                rsp_data_reg.out_x <= '0;
                rsp_data_reg.out_y <= '0;
                rsp_data_reg.out_w <= '0;
                rsp_data_reg.out_h <= '0;
            end
        end
    end

endmodule
